FILE: sv/orb_pkg.sv
// Shared types and constants for the overwrite ring buffer.
`timescale 1ns / 1ps

package orb_pkg;

    localparam int DEFAULT_DEPTH = 512;

    localparam int REQ_W    = 3;
    localparam int ID_W     = 8;
    localparam int TEMP_W   = 16;
    localparam int TS_W     = 32;
    localparam int OFFSET_W = 9;
    localparam int COUNT_W  = 10;
    localparam int OVF_W    = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 3'd0,
        REQ_POP   = 3'd1,
        REQ_PEEK  = 3'd2,
        REQ_CLEAR = 3'd3,
        REQ_STATS = 3'd4
    } t_req;

    typedef struct packed {
        logic        [ID_W-1:0]   id;
        logic signed [TEMP_W-1:0] temp;
        logic        [TS_W-1:0]   ts;
    } t_rec;

endpackage

FILE: sv/orb_mem.sv
// Record store: one write port and two registered read ports.
`timescale 1ns / 1ps

module orb_mem import orb_pkg::*; #(
    parameter int DEPTH = DEFAULT_DEPTH,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_rec             i_wdata,
    input  logic [IDX_W-1:0] i_raddr_a,
    input  logic [IDX_W-1:0] i_raddr_b,
    output t_rec             o_rdata_a,
    output t_rec             o_rdata_b
);

    t_rec r_mem [DEPTH];
    t_rec r_rdata_a;
    t_rec r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: sv/overwrite_ring_buffer.sv
// Top level of the overwrite-on-full ring buffer of sensor records.
//
//   channel   | handshake            | signals
//   ----------+----------------------+------------------------------------------
//   request   | start & !busy        | i_req_type, i_in_*, i_peek_offset
//   result    | o_done, one cycle    | o_ok, o_out_*, o_entry_count,
//             |                      | o_overflow_total, o_oldest_time, o_newest_time
//
// One item per cycle; busy stays low. The result of an item is shown in the
// cycle after it is accepted, for one cycle, set by the registered reads of
// the record store. Pointers, count and overflow counter update at the
// accept edge. Reset clears the pointers and counters; the store itself is
// not cleared. The receiver cannot stall.
`timescale 1ns / 1ps

module overwrite_ring_buffer import orb_pkg::*; #(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic [ID_W-1:0]          i_in_sensor_id,
    input  logic signed [TEMP_W-1:0] i_in_temp,
    input  logic [TS_W-1:0]          i_in_timestamp,
    input  logic [OFFSET_W-1:0]      i_peek_offset,
    output logic                     o_done,
    output logic                     o_ok,
    output logic [ID_W-1:0]          o_out_sensor_id,
    output logic signed [TEMP_W-1:0] o_out_temp,
    output logic [TS_W-1:0]          o_out_timestamp,
    output logic [COUNT_W-1:0]       o_entry_count,
    output logic [OVF_W-1:0]         o_overflow_total,
    output logic [TS_W-1:0]          o_oldest_time,
    output logic [TS_W-1:0]          o_newest_time
);

    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CMP_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SUM_W    = ((IDX_W > OFFSET_W) ? IDX_W : OFFSET_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(DEPTH);

    function automatic logic [IDX_W-1:0] f_adv(input logic [IDX_W-1:0] idx);
        f_adv = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [OVF_W-1:0] r_ovf, n_ovf;
    logic             r_done;
    logic             r_ok, n_ok;
    logic             r_show_rec, n_show_rec;
    logic             r_show_stats, n_show_stats;

    logic             accept;
    logic             mem_we;
    t_rec             mem_wdata;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] newest_idx;
    t_rec             rdata_a;
    t_rec             rdata_b;
    logic [SUM_W-1:0] peek_sum;
    logic [IDX_W-1:0] peek_addr;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] offset_ext;
    logic             count_full;
    logic             count_zero;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign mem_wdata.id   = i_in_sensor_id;
    assign mem_wdata.temp = i_in_temp;
    assign mem_wdata.ts   = i_in_timestamp;

    assign newest_idx = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
    assign peek_sum   = SUM_W'(r_head) + SUM_W'(i_peek_offset);
    assign peek_addr  = (peek_sum >= SUM_WRAP) ? IDX_W'(peek_sum - SUM_WRAP)
                                               : IDX_W'(peek_sum);
    assign count_ext  = CMP_W'(r_count);
    assign offset_ext = CMP_W'(i_peek_offset);
    assign count_full = (r_count == FULL_CNT);
    assign count_zero = (r_count == '0);

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_ok         = 1'b0;
        n_show_rec   = 1'b0;
        n_show_stats = 1'b0;
        mem_we       = 1'b0;
        raddr_a      = r_head;
        if (accept) begin
            case (t_req'(i_req_type))
                REQ_PUSH: begin
                    mem_we = 1'b1;
                    n_tail = f_adv(r_tail);
                    if (count_full) begin
                        n_head = f_adv(r_head);
                        n_ovf  = r_ovf + 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_ok    = 1'b1;
                    end
                end
                REQ_POP: begin
                    if (!count_zero) begin
                        n_head     = f_adv(r_head);
                        n_count    = r_count - 1'b1;
                        n_ok       = 1'b1;
                        n_show_rec = 1'b1;
                    end
                end
                REQ_PEEK: begin
                    raddr_a = peek_addr;
                    if (offset_ext < count_ext) begin
                        n_ok       = 1'b1;
                        n_show_rec = 1'b1;
                    end
                end
                REQ_CLEAR: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                    n_ovf   = '0;
                    n_ok    = 1'b1;
                end
                REQ_STATS: begin
                    n_ok         = 1'b1;
                    n_show_stats = !count_zero;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_ovf   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_done  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok         <= n_ok;
        r_show_rec   <= n_show_rec;
        r_show_stats <= n_show_stats;
    end

    orb_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (r_tail),
        .i_wdata   (mem_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (newest_idx),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    logic [CMP_W-1:0] entry_ext;

    assign entry_ext        = CMP_W'(r_count);
    assign o_done           = r_done;
    assign o_ok             = r_ok;
    assign o_out_sensor_id  = r_show_rec ? rdata_a.id : '0;
    assign o_out_temp       = r_show_rec ? rdata_a.temp : '0;
    assign o_out_timestamp  = r_show_rec ? rdata_a.ts : '0;
    assign o_entry_count    = entry_ext[COUNT_W-1:0];
    assign o_overflow_total = r_ovf;
    assign o_oldest_time    = r_show_stats ? rdata_a.ts : '0;
    assign o_newest_time    = r_show_stats ? rdata_b.ts : '0;

endmodule
